// File: rtl/swfe_pkg.sv
// ----------------------------------------------------------------------------
// swfe_pkg
// Shared widths, accumulator record and controller states for the sliding
// window feature extractor.
// ----------------------------------------------------------------------------
package swfe_pkg;

  localparam int CH_W     = 6;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;   // sum of up to 256 samples
  localparam int SQ_W     = 40;   // sum of squares of up to 256 samples
  localparam int WS_W     = 32;   // index-weighted sum
  localparam int MEAN_W   = 24;
  localparam int DEV_W    = 23;
  localparam int SLOPE_W  = 25;
  localparam int RANGE_W  = 16;
  localparam int NET_W    = 17;
  localparam int DVD_W    = 64;   // divider dividend and quotient
  localparam int DVS_W    = 32;   // divider divisor
  localparam int ROOT_W   = 32;

  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic [SQ_W-1:0]     sumsq;
    logic [WS_W-1:0]     wsum;
    logic [SAMPLE_W-1:0] mn;
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] oldest;
    logic [SAMPLE_W-1:0] newest;
  } window_acc_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_VAR_GO,
    S_VAR_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_SLOPE_GO,
    S_SLOPE_WAIT,
    S_EMIT
  } ctrl_state_t;

endpackage

// File: rtl/swfe_sample_if.sv
// ----------------------------------------------------------------------------
// swfe_sample_if
// Input channel: one channel sample per transaction.
// ----------------------------------------------------------------------------
interface swfe_sample_if;
  import swfe_pkg::*;

  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [SAMPLE_W-1:0] sample;
  logic                frame_end;

  modport source (output valid, output channel, output sample, output frame_end,
                  input ready);
  modport sink   (input valid, input channel, input sample, input frame_end,
                  output ready);
endinterface

// File: rtl/swfe_feature_if.sv
// ----------------------------------------------------------------------------
// swfe_feature_if
// Output channel: one feature record per transaction.
// ----------------------------------------------------------------------------
interface swfe_feature_if;
  import swfe_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CH_W-1:0]           feature_channel;
  logic [MEAN_W-1:0]         window_mean;
  logic [DEV_W-1:0]          window_deviation;
  logic signed [SLOPE_W-1:0] window_slope;
  logic [RANGE_W-1:0]        window_range;
  logic signed [NET_W-1:0]   net_change;

  modport source (output valid, output feature_channel, output window_mean,
                  output window_deviation, output window_slope, output window_range,
                  output net_change, input ready);
  modport sink   (input valid, input feature_channel, input window_mean,
                  input window_deviation, input window_slope, input window_range,
                  input net_change, output ready);
endinterface

// File: rtl/swfe_window.sv
// ----------------------------------------------------------------------------
// swfe_window
// Sample memory for all channel windows and the scan that walks one channel's
// window oldest to newest, accumulating sums, extremes and end points.
// ----------------------------------------------------------------------------
module swfe_window #(
  parameter int WINDOW   = 40,
  parameter int CHANNELS = 35,
  localparam int HW      = $clog2(WINDOW),
  localparam int DEPTH   = WINDOW * CHANNELS,
  localparam int AW      = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [HW-1:0]                wr_slot,
  input  logic [swfe_pkg::CH_W-1:0]    wr_ch,
  input  logic [swfe_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                         scan_start,
  input  logic [HW-1:0]                scan_slot,
  input  logic [swfe_pkg::CH_W-1:0]    scan_ch,
  output swfe_pkg::window_acc_t        acc,
  output logic                         acc_done
);
  import swfe_pkg::*;

  localparam logic [HW-1:0] LAST = HW'(WINDOW - 1);

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;

  logic                scanning;
  logic [HW-1:0]       slot;
  logic [HW-1:0]       k_iss;
  logic [CH_W-1:0]     ch_s;
  logic                rvalid;
  logic [HW-1:0]       k_d;

  logic [SUM_W-1:0]    x_sum;
  logic [SQ_W-1:0]     x_sq;
  logic [WS_W-1:0]     x_w;

  assign waddr = AW'(wr_slot * CHANNELS + wr_ch);
  assign raddr = AW'(slot * CHANNELS + ch_s);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wr_data;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      rvalid   <= 1'b0;
      acc_done <= 1'b0;
    end else begin
      rvalid   <= scanning;
      acc_done <= rvalid && (k_d == LAST);
      if (scan_start) begin
        scanning <= 1'b1;
      end else if (scanning && k_iss == LAST) begin
        scanning <= 1'b0;
      end
    end
  end

  // Advance the read slot around the ring, starting just past the head.
  always_ff @(posedge clk) begin
    k_d <= k_iss;
    if (scan_start) begin
      slot  <= scan_slot;
      k_iss <= '0;
      ch_s  <= scan_ch;
    end else if (scanning) begin
      slot  <= (slot == LAST) ? '0 : slot + 1'b1;
      k_iss <= k_iss + 1'b1;
    end
  end

  assign x_sum = SUM_W'(rdata);
  assign x_sq  = SQ_W'(rdata) * SQ_W'(rdata);
  assign x_w   = WS_W'(k_d) * WS_W'(rdata);

  always_ff @(posedge clk) begin
    if (rvalid) begin
      acc.newest <= rdata;
      if (k_d == '0) begin
        acc.sum    <= x_sum;
        acc.sumsq  <= x_sq;
        acc.wsum   <= '0;
        acc.mn     <= rdata;
        acc.mx     <= rdata;
        acc.oldest <= rdata;
      end else begin
        acc.sum   <= acc.sum + x_sum;
        acc.sumsq <= acc.sumsq + x_sq;
        acc.wsum  <= acc.wsum + x_w;
        if (rdata < acc.mn) acc.mn <= rdata;
        if (rdata > acc.mx) acc.mx <= rdata;
      end
    end
  end

endmodule

// File: rtl/swfe_divider.sv
// ----------------------------------------------------------------------------
// swfe_divider
// Unsigned division by a constant: multiply by the precomputed reciprocal on
// one 32x32 multiplier in four partial products, multiply the estimate back
// in two, then correct it by at most one.
// ----------------------------------------------------------------------------
module swfe_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [swfe_pkg::DVD_W-1:0] dividend,
  input  logic [swfe_pkg::DVS_W-1:0] divisor,
  input  logic [swfe_pkg::DVD_W-1:0] recip,
  output logic [swfe_pkg::DVD_W-1:0] quotient,
  output logic                       busy,
  output logic                       done
);
  import swfe_pkg::*;

  localparam int PW = 2 * DVD_W;

  logic [DVD_W-1:0] num;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] rcp;
  logic [PW-1:0]    pacc;
  logic [DVD_W-1:0] back;
  logic [DVD_W-1:0] rem;
  logic [DVD_W-1:0] quo;
  logic [2:0]       cnt;
  logic [DVS_W-1:0] mul_a;
  logic [DVS_W-1:0] mul_b;
  logic [DVD_W-1:0] prod;
  logic [DVD_W-1:0] q_est;

  // The estimate never exceeds the true quotient and is at most one below it.
  assign q_est    = pacc[PW-1:DVD_W];
  assign prod     = DVD_W'(mul_a) * DVD_W'(mul_b);
  assign quotient = quo;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cnt)
      3'd0: begin
        mul_a = num[DVS_W-1:0];
        mul_b = rcp[DVS_W-1:0];
      end
      3'd1: begin
        mul_a = num[DVS_W-1:0];
        mul_b = rcp[DVD_W-1:DVS_W];
      end
      3'd2: begin
        mul_a = num[DVD_W-1:DVS_W];
        mul_b = rcp[DVS_W-1:0];
      end
      3'd3: begin
        mul_a = num[DVD_W-1:DVS_W];
        mul_b = rcp[DVD_W-1:DVS_W];
      end
      3'd4: begin
        mul_a = q_est[DVS_W-1:0];
        mul_b = dvs;
      end
      3'd5: begin
        mul_a = q_est[DVD_W-1:DVS_W];
        mul_b = dvs;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 3'd7) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      dvs <= divisor;
      rcp <= recip;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      case (cnt)
        3'd0: pacc <= PW'(prod);
        3'd1: pacc <= pacc + (PW'(prod) << DVS_W);
        3'd2: pacc <= pacc + (PW'(prod) << DVS_W);
        3'd3: pacc <= pacc + (PW'(prod) << DVD_W);
        3'd4: back <= prod;
        3'd5: back <= back + {prod[DVS_W-1:0], {DVS_W{1'b0}}};
        3'd6: rem  <= num - back;
        3'd7: quo  <= (rem >= DVD_W'(dvs)) ? q_est + 1'b1 : q_est;
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/swfe_isqrt.sv
// ----------------------------------------------------------------------------
// swfe_isqrt
// Integer square root, floor, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module swfe_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [swfe_pkg::DVD_W-1:0]  radicand,
  output logic [swfe_pkg::ROOT_W-1:0] root,
  output logic                        busy,
  output logic                        done
);
  import swfe_pkg::*;

  localparam int CW = $clog2(DVD_W / 2);

  logic [DVD_W-1:0] v;
  logic [DVD_W-1:0] res;
  logic [DVD_W-1:0] bitm;
  logic [DVD_W-1:0] cand;
  logic [CW-1:0]    cnt;

  assign cand = res + bitm;
  assign root = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CW'(DVD_W / 2 - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitm <= {2'b01, {(DVD_W - 2){1'b0}}};
      cnt  <= '0;
    end else if (busy) begin
      if (v >= cand) begin
        v   <= v - cand;
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
      cnt  <= cnt + 1'b1;
    end
  end

endmodule

// File: rtl/sliding_window_feature_extractor_top.sv
// ----------------------------------------------------------------------------
// sliding_window_feature_extractor_top
// Per-channel sliding window statistics: mean, deviation, slope, range and
// net change over the last WINDOW frames.
// ----------------------------------------------------------------------------
// Usage:
//   samples  : one transaction per channel sample; frame_end marks the last
//              sample of a frame and advances the shared write head.
//   features : one transaction per stored sample once the windows are full
//              (the frame that completes the first fill already reports).
//   Channels at or above CHANNELS are dropped; their frame_end still counts.
// Timing: a sample that yields no record leaves the controller idle. For a
//   sample that does, the record comes from a memory scan, three passes of
//   the shared constant divider (mean, variance, slope) and a square root,
//   and the next sample is accepted once that record enters the output register.
//   One sample is processed at a time; samples.ready is high only when idle.
// Reset: clears the write head, the fill flag and the output valid, not the
//   memory. The user must write each slot before it is read; the block does not check.
// Stall: a finished record waits in the output register; the next sample is
//   accepted meanwhile, and its record waits until the register is taken.
// ----------------------------------------------------------------------------
module sliding_window_feature_extractor_top #(
  parameter int WINDOW   = 40,
  parameter int CHANNELS = 35
) (
  input logic           clk,
  input logic           rst,
  swfe_sample_if.sink    samples,
  swfe_feature_if.source features
);
  import swfe_pkg::*;

  localparam int HW = $clog2(WINDOW);
  localparam logic [HW-1:0]    HEAD_LAST = HW'(WINDOW - 1);
  localparam logic [DVS_W-1:0] DIV_WIN   = DVS_W'(WINDOW);
  localparam logic [DVS_W-1:0] DIV_WSQ   = DVS_W'(WINDOW * WINDOW);
  localparam logic [DVS_W-1:0] DIV_DEN   = DVS_W'(WINDOW * (WINDOW * WINDOW - 1));
  localparam logic [DVD_W-1:0] RCP_WIN   = 64'hFFFF_FFFF_FFFF_FFFF / DVD_W'(DIV_WIN);
  localparam logic [DVD_W-1:0] RCP_WSQ   = 64'hFFFF_FFFF_FFFF_FFFF / DVD_W'(DIV_WSQ);
  localparam logic [DVD_W-1:0] RCP_DEN   = 64'hFFFF_FFFF_FFFF_FFFF / DVD_W'(DIV_DEN);

  ctrl_state_t state, state_next;

  logic [HW-1:0]   write_head;
  logic            window_full;
  logic            accept;
  logic            in_range;
  logic            need_result;
  logic [HW-1:0]   scan_slot;
  logic [CH_W-1:0] ch_q;

  window_acc_t     acc;
  logic            acc_done;

  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_recip;
  logic [DVD_W-1:0] div_quotient;
  logic             div_busy;
  logic             div_done;

  logic              root_start;
  logic [ROOT_W-1:0] root_val;
  logic              root_busy;
  logic              root_done;

  logic [DVD_W-1:0]   spread_q;
  logic [47:0]        s2_u;
  logic [47:0]        s2_mag;
  logic               s2_neg;
  logic [DVD_W-1:0]   var_q;
  logic [MEAN_W-1:0]  mean_q;
  logic [DEV_W-1:0]   dev_q;
  logic [SLOPE_W-1:0] slope_q;
  logic [RANGE_W-1:0] range_q;
  logic [NET_W-1:0]   net_q;

  logic               out_valid;
  logic               out_load;
  logic [CH_W-1:0]    out_channel;
  logic [MEAN_W-1:0]  out_mean;
  logic [DEV_W-1:0]   out_dev;
  logic [SLOPE_W-1:0] out_slope;
  logic [RANGE_W-1:0] out_range;
  logic [NET_W-1:0]   out_net;

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign in_range      = {1'b0, samples.channel} < (CH_W + 1)'(CHANNELS);
  assign need_result   = in_range && (window_full || write_head == HEAD_LAST);
  assign scan_slot     = (write_head == HEAD_LAST) ? '0 : write_head + 1'b1;

  swfe_window #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (accept && in_range),
    .wr_slot    (write_head),
    .wr_ch      (samples.channel),
    .wr_data    (samples.sample),
    .scan_start (accept && need_result),
    .scan_slot  (scan_slot),
    .scan_ch    (samples.channel),
    .acc        (acc),
    .acc_done   (acc_done)
  );

  swfe_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .recip    (div_recip),
    .quotient (div_quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  swfe_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (var_q),
    .root     (root_val),
    .busy     (root_busy),
    .done     (root_done)
  );

  // Head and fill flag
  always_ff @(posedge clk) begin
    if (rst) begin
      write_head  <= '0;
      window_full <= 1'b0;
    end else if (accept && samples.frame_end) begin
      if (write_head == HEAD_LAST) begin
        write_head  <= '0;
        window_full <= 1'b1;
      end else begin
        write_head <= write_head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DIV_WIN;
    div_recip    = RCP_WIN;
    root_start   = 1'b0;
    out_load     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept && need_result) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (acc_done) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'({acc.sum, 8'b0});
        div_divisor  = DIV_WIN;
        div_recip    = RCP_WIN;
        state_next   = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_done) state_next = S_VAR_GO;
      end
      S_VAR_GO: begin
        div_start    = 1'b1;
        div_dividend = {spread_q[DVD_W-17:0], 16'b0};
        div_divisor  = DIV_WSQ;
        div_recip    = RCP_WSQ;
        state_next   = S_VAR_WAIT;
      end
      S_VAR_WAIT: begin
        if (div_done) state_next = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        root_start = 1'b1;
        state_next = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (root_done) state_next = S_SLOPE_GO;
      end
      S_SLOPE_GO: begin
        div_start    = 1'b1;
        // times 1536 = 1024 + 512
        div_dividend = DVD_W'({s2_mag, 10'b0}) + DVD_W'({s2_mag, 9'b0});
        div_divisor  = DIV_DEN;
        div_recip    = RCP_DEN;
        state_next   = S_SLOPE_WAIT;
      end
      S_SLOPE_WAIT: begin
        if (div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || features.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign s2_u   = {15'b0, acc.wsum, 1'b0} - 48'(WINDOW - 1) * 48'(acc.sum);
  assign s2_mag = s2_neg ? -s2_u : s2_u;

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_q <= samples.channel;
    end
    if (state == S_PREP) begin
      spread_q <= 64'(WINDOW) * 64'(acc.sumsq) - 64'(acc.sum) * 64'(acc.sum);
      range_q  <= acc.mx - acc.mn;
      net_q    <= NET_W'({1'b0, acc.newest}) - NET_W'({1'b0, acc.oldest});
      s2_neg   <= s2_u[47];
    end
    if (state == S_MEAN_WAIT && div_done) begin
      mean_q <= div_quotient[MEAN_W-1:0];
    end
    if (state == S_VAR_WAIT && div_done) begin
      var_q <= div_quotient;
    end
    if (state == S_ROOT_WAIT && root_done) begin
      dev_q <= root_val[DEV_W-1:0];
    end
    if (state == S_SLOPE_WAIT && div_done) begin
      slope_q <= s2_neg ? -div_quotient[SLOPE_W-1:0] : div_quotient[SLOPE_W-1:0];
    end
  end

  // Output register: hold the record until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (features.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_channel <= ch_q;
      out_mean    <= mean_q;
      out_dev     <= dev_q;
      out_slope   <= slope_q;
      out_range   <= range_q;
      out_net     <= net_q;
    end
  end

  assign features.valid            = out_valid;
  assign features.feature_channel  = out_channel;
  assign features.window_mean      = out_mean;
  assign features.window_deviation = out_dev;
  assign features.window_slope     = $signed(out_slope);
  assign features.window_range     = out_range;
  assign features.net_change       = $signed(out_net);

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_root_idle_start: assert property (@(posedge clk) disable iff (rst)
    root_start |-> !root_busy && !div_busy)
    else $error("square root started while a unit is busy");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    write_head <= HEAD_LAST)
    else $error("write head past window end");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    window_full |=> window_full)
    else $error("window full flag dropped");

endmodule

// File: verif/tb_sliding_window_feature_extractor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_feature_extractor_top
// Drives channel samples through the first window fill, a directed pass over
// the extremes and a long random pass, predicts every feature record and
// compares it field by field as the records come out.
// ----------------------------------------------------------------------------
module tb_sliding_window_feature_extractor_top;
  import swfe_pkg::*;

  localparam int WINDOW   = 40;
  localparam int CHANNELS = 35;
  localparam int MAX_CH   = (1 << CH_W) - 1;
  localparam int MAX_SMP  = (1 << SAMPLE_W) - 1;

  typedef struct {
    logic [CH_W-1:0]           ch;
    logic [MEAN_W-1:0]         mean;
    logic [DEV_W-1:0]          dev;
    logic signed [SLOPE_W-1:0] slope;
    logic [RANGE_W-1:0]        range;
    logic signed [NET_W-1:0]   net;
  } features_t;

  logic clk;
  logic rst;

  swfe_sample_if  samples ();
  swfe_feature_if features ();

  sliding_window_feature_extractor_top #(
    .WINDOW(WINDOW),
    .CHANNELS(CHANNELS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .samples(samples),
    .features(features)
  );

  // Mirror of the window store and head
  logic [SAMPLE_W-1:0] window_mem [WINDOW][CHANNELS];
  int unsigned         head;
  bit                  filled;

  features_t pending_features [$];
  int        errors;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("sliding_window_feature_extractor_top: mismatch");
    $finish;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    lo = 0;
    hi = 64'hFFFF_FFFF;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Store the sample, then work out the record it causes, if any.
  task automatic predict_features(input int ch, input int smp, input bit fend);
    longint unsigned sum, sumsq, wsum, spread, x;
    longint          s2, den, slope;
    longint unsigned mn, mx, oldest, newest;
    int unsigned     slot;
    features_t       f;
    sum = 0;
    sumsq = 0;
    wsum = 0;
    mn = MAX_SMP;
    mx = 0;
    oldest = 0;
    newest = 0;
    if (ch < CHANNELS) begin
      window_mem[head][ch] = SAMPLE_W'(smp);
      if (filled || head == WINDOW - 1) begin
        for (int k = 0; k < WINDOW; k++) begin
          slot = (head + 1 + k) % WINDOW;
          x = 64'(window_mem[slot][ch]);
          sum += x;
          sumsq += x * x;
          wsum += k * x;
          if (x < mn) mn = x;
          if (x > mx) mx = x;
          if (k == 0) oldest = x;
          if (k == WINDOW - 1) newest = x;
        end
        spread = WINDOW * sumsq - sum * sum;
        s2 = longint'(2 * wsum) - longint'((WINDOW - 1) * sum);
        den = WINDOW * (WINDOW * WINDOW - 1);
        slope = (s2 * 1536) / den;
        f.ch = CH_W'(ch);
        f.mean = MEAN_W'((sum * 256) / WINDOW);
        f.dev = DEV_W'(floor_root((spread * 65536) / (WINDOW * WINDOW)));
        f.slope = SLOPE_W'(slope);
        f.range = RANGE_W'(mx - mn);
        f.net = NET_W'(longint'(newest) - longint'(oldest));
        pending_features.push_back(f);
      end
    end
    if (fend) begin
      if (head == WINDOW - 1) begin
        head = 0;
        filled = 1'b1;
      end else begin
        head++;
      end
    end
  endtask

  // One transaction on the sample channel, with bursts and gaps between them
  task automatic send_sample(input int ch, input int smp, input bit fend);
    samples.valid     <= 1'b1;
    samples.channel   <= CH_W'(ch);
    samples.sample    <= SAMPLE_W'(smp);
    samples.frame_end <= fend;
    do @(posedge clk); while (!samples.ready);
    predict_features(ch, smp, fend);
    if (burst_left == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Receiver stall pattern: long clean stretches, then heavy random stalls, then light ones
  int unsigned stall_tick;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (rst) features.ready <= 1'b1;
    else if (stall_tick[11]) features.ready <= ($urandom_range(0, 2) != 0);
    else if (stall_tick[10]) features.ready <= ($urandom_range(0, 15) == 0);
    else features.ready <= 1'b1;
  end

  always @(posedge clk) begin
    features_t e;
    if (!rst && features.valid && features.ready) begin
      if (pending_features.size() == 0) begin
        $display("%0t: record exp none got channel %0d", $time,
                 features.feature_channel);
        errors++;
      end else begin
        e = pending_features.pop_front();
        if (features.feature_channel !== e.ch) begin
          $display("%0t: channel exp %0d got %0d", $time, e.ch,
                   features.feature_channel);
          errors++;
        end
        if (features.window_mean !== e.mean) begin
          $display("%0t: mean exp %0d got %0d", $time, e.mean, features.window_mean);
          errors++;
        end
        if (features.window_deviation !== e.dev) begin
          $display("%0t: deviation exp %0d got %0d", $time, e.dev,
                   features.window_deviation);
          errors++;
        end
        if (features.window_slope !== e.slope) begin
          $display("%0t: slope exp %0d got %0d", $time, e.slope, features.window_slope);
          errors++;
        end
        if (features.window_range !== e.range) begin
          $display("%0t: range exp %0d got %0d", $time, e.range, features.window_range);
          errors++;
        end
        if (features.net_change !== e.net) begin
          $display("%0t: net change exp %0d got %0d", $time, e.net, features.net_change);
          errors++;
        end
      end
    end
  end

  function automatic int pick_sample();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return MAX_SMP;
      2: return $urandom_range(0, 255);
      default: return $urandom_range(0, MAX_SMP);
    endcase
  endfunction

  // Every channel is written in every frame until the window has filled, so
  // no slot is read before it holds a sample. Shapes on a few channels hit
  // the extremes of slope, range and net change on the completing frame.
  task automatic test_first_fill();
    int smp;
    for (int fr = 0; fr < WINDOW; fr++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        case (ch)
          0:  smp = (fr == WINDOW - 1) ? MAX_SMP : fr * 1680;
          1:  smp = (fr == WINDOW - 1) ? 0 : MAX_SMP - fr * 1680;
          2:  smp = MAX_SMP;
          3:  smp = 0;
          34: smp = fr[0] ? MAX_SMP : 0;
          default: smp = pick_sample();
        endcase
        send_sample(ch, smp, 1'b0);
        if (fr == 5 && ch == 10) send_sample(MAX_CH, MAX_SMP, 1'b0);
      end
      // drop frame end onto an ignored channel once
      if (fr == 20) send_sample(CHANNELS, 16'h5A5A, 1'b1);
      else send_sample(($urandom_range(0, 1) != 0) ? 0 : 34, pick_sample(), 1'b1);
    end
  endtask

  task automatic test_directed();
    // repeated channel overwrites its slot
    send_sample(5, MAX_SMP, 1'b0);
    send_sample(5, 0, 1'b0);
    send_sample(5, 12345, 1'b1);
    // single-channel frames: others keep their older values
    for (int i = 0; i < 10; i++) send_sample(0, i[0] ? MAX_SMP : 0, 1'b1);
    send_sample(MAX_CH, 0, 1'b1);
    send_sample(42, MAX_SMP, 1'b0);
    send_sample(CHANNELS - 1, MAX_SMP, 1'b0);
    send_sample(2, 0, 1'b1);
    send_sample(3, MAX_SMP, 1'b1);
  endtask

  // Hold the sender until every pending record has drained
  task automatic test_drain_pause();
    samples.valid <= 1'b0;
    burst_left = 0;
    wait (pending_features.size() == 0);
    @(posedge clk);
    send_sample(7, pick_sample(), 1'b1);
  endtask

  task automatic test_random(input int n_items);
    int sent;
    int ch;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        // well-formed frame, channels in order, some skipped
        for (ch = 0; ch < CHANNELS && sent < n_items; ch++) begin
          if ($urandom_range(0, 9) != 0) begin
            send_sample(ch, pick_sample(), 1'b0);
            sent++;
          end
        end
        send_sample($urandom_range(0, 3) == 0 ? $urandom_range(CHANNELS, MAX_CH)
                                              : $urandom_range(0, CHANNELS - 1),
                    pick_sample(), 1'b1);
        sent++;
      end else begin
        repeat ($urandom_range(1, 12)) begin
          ch = ($urandom_range(0, 3) == 0) ? $urandom_range(CHANNELS, MAX_CH)
                                           : $urandom_range(0, CHANNELS - 1);
          send_sample(ch, pick_sample(), $urandom_range(0, 5) == 0);
          sent++;
        end
      end
      if ($urandom_range(0, 19) == 0) test_drain_pause();
    end
  endtask

  initial begin
    errors = 0;
    head = 0;
    filled = 1'b0;
    burst_left = 0;
    stall_tick = 0;
    samples.valid = 1'b0;
    samples.channel = '0;
    samples.sample = '0;
    samples.frame_end = 1'b0;
    features.ready = 1'b1;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_fill();
    test_directed();
    test_drain_pause();
    test_random(420);
    samples.valid <= 1'b0;
    wait (pending_features.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_features.size() == 0)
      $display("sliding_window_feature_extractor_top: match");
    else
      $display("sliding_window_feature_extractor_top: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/swfe_pkg.sv
rtl/swfe_sample_if.sv
rtl/swfe_feature_if.sv
rtl/swfe_window.sv
rtl/swfe_divider.sv
rtl/swfe_isqrt.sv
rtl/sliding_window_feature_extractor_top.sv
verif/tb_sliding_window_feature_extractor_top.sv
